@@ src/garip_pkg.sv @@
// Shared types, port codes and helper functions of the gate array register block.
`timescale 1ns / 1ps
`default_nettype none

package garip_pkg;

  // Number of keyboard rows scanned by a read of the keyboard port.
  localparam int unsigned KEY_ROWS = 8;

  typedef enum logic [2:0] {
    OP_READ       = 3'd0,
    OP_WRITE      = 3'd1,
    OP_TICK       = 3'd2,
    OP_FLAP_OPEN  = 3'd3,
    OP_FLAP_CLOSE = 3'd4,
    OP_BATT_LOW   = 3'd5,
    OP_SOFT_RESET = 3'd6
  } op_e_t;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Port addresses (low byte of the port address).
  localparam logic [7:0] PORT_LCD0   = 8'h70;
  localparam logic [7:0] PORT_LCD1   = 8'h71;
  localparam logic [7:0] PORT_LCD2   = 8'h72;
  localparam logic [7:0] PORT_LCD3   = 8'h73;
  localparam logic [7:0] PORT_SCR    = 8'h74;
  localparam logic [7:0] PORT_COM    = 8'hB0;
  localparam logic [7:0] PORT_INT    = 8'hB1;
  localparam logic [7:0] PORT_KBD    = 8'hB2;
  localparam logic [7:0] PORT_EPR    = 8'hB3;
  localparam logic [7:0] PORT_TACK   = 8'hB4;
  localparam logic [7:0] PORT_TMK    = 8'hB5;
  localparam logic [7:0] PORT_ACK    = 8'hB6;
  localparam logic [7:0] PORT_SEG0   = 8'hD0;
  localparam logic [7:0] PORT_SEG1   = 8'hD1;
  localparam logic [7:0] PORT_SEG2   = 8'hD2;
  localparam logic [7:0] PORT_SEG3   = 8'hD3;
  localparam logic [7:0] PORT_RTC4   = 8'hD4;
  localparam logic [7:0] PORT_UDAT0  = 8'hE0;
  localparam logic [7:0] PORT_UDAT1  = 8'hE1;
  localparam logic [7:0] PORT_USTA   = 8'hE5;

  // Fixed read values.
  localparam logic [7:0] STA_READ_VAL  = 8'h80;
  localparam logic [7:0] USTA_READ_VAL = 8'h10;
  localparam logic [7:0] IDLE_READ_VAL = 8'hFF;

  // Real-time clock limits.
  localparam logic [7:0] RTC_TICK_MAX = 8'd199;
  localparam logic [7:0] RTC_SEC_AT   = 8'h80;
  localparam logic [7:0] RTC_MIN_MAX  = 8'd59;
  localparam logic [7:0] RTC_HALF_MIN = 8'd32;
  localparam logic [7:0] RTC_DAY_MAX  = 8'd31;

  // Timer event codes.
  localparam logic [2:0] TEV_NONE = 3'b000;
  localparam logic [2:0] TEV_TICK = 3'b001;
  localparam logic [2:0] TEV_SEC  = 3'b010;
  localparam logic [2:0] TEV_MIN  = 3'b100;

  // Reset values and masks.
  localparam logic [7:0] IEN_RESET     = 8'h23;
  localparam logic [7:0] TMASK_RESET   = 8'h01;
  localparam logic [7:0] STA_TIME_CLR  = 8'hFE;
  localparam logic [7:0] STA_TIME_BIT  = 8'h01;
  localparam logic [7:0] STA_FLAP_BITS = 8'hA0;
  localparam logic [7:0] STA_FLAP_CLR  = 8'h7F;
  localparam logic [7:0] STA_BATT_BIT  = 8'h08;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] port_address;
    logic [7:0]  write_data;
    logic        key_pressed;
    logic [63:0] key_matrix;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_out;
    logic        wake_cpu;
    logic        snooze_cpu;
    logic        speaker_out;
    logic [31:0] segment_banks;
    logic [7:0]  seg0_lower_bank;
    logic [63:0] lcd_bases;
    logic [15:0] screen_base_word;
  } result_t;

  // The interrupt line pairs enable bits with status bits position by position.
  function automatic logic irq_eval(input logic [7:0] ien, input logic [7:0] ist);
    irq_eval = ien[0] & (|(ien & ist));
  endfunction

  // True when v is a multiple of three: base-4 digit sums keep the residue mod 3.
  function automatic logic mod3_zero(input logic [7:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]};
    mod3_zero = (s2 == 3'd0) || (s2 == 3'd3) || (s2 == 3'd6);
  endfunction

endpackage

`default_nettype wire

@@ src/garip_kbd.sv @@
// Keyboard matrix read: ORs the rows selected (active low) by the address high byte.
`timescale 1ns / 1ps
`default_nettype none

module garip_kbd
  import garip_pkg::*;
(
  input  wire logic [7:0]  row_sel,
  input  wire logic [63:0] key_matrix,
  output logic      [7:0]  key_data
);

  logic [7:0] acc;

  always_comb begin
    acc = 8'h00;
    for (int i = 0; i < KEY_ROWS; i++) begin
      if (!row_sel[i]) begin
        acc = acc | key_matrix[8*i +: 8];
      end
    end
    key_data = ~acc;
  end

endmodule

`default_nettype wire

@@ src/garip_rtc.sv @@
// Next value of the five real-time counters on a clock tick, and the timer event.
`timescale 1ns / 1ps
`default_nettype none

module garip_rtc
  import garip_pkg::*;
(
  input  wire logic [4:0][7:0] cnt,
  output logic      [4:0][7:0] cnt_nxt,
  output logic      [2:0]      tev
);

  logic [7:0] c0_inc;
  logic [7:0] c1_inc;
  logic [7:0] c2_inc;
  logic [7:0] c3_inc;
  logic [7:0] c4_inc;

  assign c0_inc = cnt[0] + 8'd1;
  assign c1_inc = cnt[1] + 8'd1;
  assign c2_inc = cnt[2] + 8'd1;
  assign c3_inc = cnt[3] + 8'd1;
  assign c4_inc = cnt[4] + 8'd1;

  always_comb begin
    cnt_nxt = cnt;
    tev     = TEV_NONE;
    if (c0_inc > RTC_TICK_MAX) begin
      cnt_nxt[0] = 8'd0;
    end else begin
      cnt_nxt[0] = c0_inc;
      if (c0_inc[0]) begin
        tev = TEV_TICK;
      end
      if (c0_inc == RTC_SEC_AT) begin
        tev = TEV_SEC;
        if (c1_inc > RTC_MIN_MAX) begin
          cnt_nxt[1] = 8'd0;
          cnt_nxt[2] = c2_inc;
          // Carries ripple only when the lower counter wraps through zero.
          if (c2_inc == 8'd0) begin
            cnt_nxt[3] = c3_inc;
            if (c3_inc == 8'd0) begin
              cnt_nxt[4] = (c4_inc > RTC_DAY_MAX) ? 8'd0 : c4_inc;
            end
          end
        end else begin
          cnt_nxt[1] = c1_inc;
          if (c1_inc == RTC_HALF_MIN) begin
            tev = TEV_MIN;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/garip_core.sv @@
// Register file of the gate array and the per-item update and result logic.
`timescale 1ns / 1ps
`default_nettype none

module garip_core
  import garip_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire item_t      item,
  input  wire logic [7:0] width_code,
  input  wire logic [7:0] height_code,
  output result_t         res_nxt
);

  logic [3:0][7:0]  seg_r,   seg_nxt;
  logic [4:0][7:0]  rtc_r,   rtc_nxt;
  logic [2:0]       ts_r,    ts_nxt;
  logic [7:0]       tmask_r, tmask_nxt;
  logic [7:0]       ien_r,   ien_nxt;
  logic [7:0]       ist_r,   ist_nxt;
  logic [7:0]       cmd_r,   cmd_nxt;
  logic             irq_r,   irq_nxt;
  logic [3:0][15:0] lcd_r,   lcd_nxt;
  logic [15:0]      scr_r,   scr_nxt;
  logic             spk_r,   spk_nxt;
  logic             lower_r, lower_nxt;

  logic [4:0][7:0] rtc_tick;
  logic [2:0]      tev;
  logic [7:0]      key_data;
  logic [7:0]      port;
  logic [7:0]      wd;
  logic [7:0]      rd;
  logic [7:0]      ist_tmp;
  logic [2:0]      ts_tmp;
  logic            wake;
  logic            snooze;
  op_e_t           op;

  assign port = item.port_address[7:0];
  assign wd   = item.write_data;
  assign op   = op_e_t'(item.operation);

  garip_rtc u_rtc (
    .cnt     (rtc_r),
    .cnt_nxt (rtc_tick),
    .tev     (tev)
  );

  garip_kbd u_kbd (
    .row_sel    (item.port_address[15:8]),
    .key_matrix (item.key_matrix),
    .key_data   (key_data)
  );

  always_comb begin
    seg_nxt   = seg_r;
    rtc_nxt   = rtc_r;
    ts_nxt    = ts_r;
    tmask_nxt = tmask_r;
    ien_nxt   = ien_r;
    ist_nxt   = ist_r;
    cmd_nxt   = cmd_r;
    irq_nxt   = irq_r;
    lcd_nxt   = lcd_r;
    scr_nxt   = scr_r;
    spk_nxt   = spk_r;
    lower_nxt = lower_r;
    rd        = IDLE_READ_VAL;
    wake      = 1'b0;
    snooze    = 1'b0;
    ist_tmp   = ist_r;
    ts_tmp    = ts_r;

    case (op)
      OP_READ: begin
        case (port)
          PORT_COM: rd = STA_READ_VAL;
          PORT_INT: rd = ist_r;
          PORT_KBD: begin
            // Keyboard wait: no key down and wait enabled puts the CPU to snooze.
            if (ien_r[7] && !item.key_pressed) begin
              snooze = 1'b1;
            end else begin
              rd = key_data;
            end
          end
          PORT_TMK: rd = {5'b00000, ts_r};
          PORT_SEG0, PORT_SEG1, PORT_SEG2, PORT_SEG3, PORT_RTC4: rd = rtc_r[port[2:0]];
          PORT_LCD0: rd = width_code;
          PORT_LCD1: rd = height_code;
          PORT_UDAT0, PORT_UDAT1: rd = 8'h00;
          PORT_USTA: rd = USTA_READ_VAL;
          default: rd = IDLE_READ_VAL;
        endcase
      end
      OP_WRITE: begin
        case (port)
          PORT_LCD0, PORT_LCD1, PORT_LCD2, PORT_LCD3: begin
            lcd_nxt[port[1:0]] = {item.port_address[15:8], wd};
          end
          PORT_SCR: scr_nxt = {item.port_address[15:8], wd};
          PORT_SEG0, PORT_SEG1, PORT_SEG2, PORT_SEG3: begin
            seg_nxt[port[1:0]] = wd;
            if (port == PORT_SEG0) begin
              lower_nxt = cmd_r[2];
            end
          end
          PORT_COM: begin
            cmd_nxt = wd;
            if (wd[4]) begin
              rtc_nxt   = '0;
              ts_nxt    = 3'b000;
              tmask_nxt = TMASK_RESET;
            end
            if (!wd[7]) begin
              spk_nxt = wd[6];
            end
            // Segment zero is repaged with the new RAM-select bit.
            lower_nxt = wd[2];
          end
          PORT_INT: begin
            ien_nxt = wd;
            irq_nxt = irq_eval(wd, ist_r);
          end
          PORT_TACK: begin
            ts_tmp = ts_r & ~wd[2:0];
            ts_nxt = ts_tmp;
            if (ts_tmp == 3'b000) begin
              ist_tmp = ist_r & STA_TIME_CLR;
              ist_nxt = ist_tmp;
              irq_nxt = irq_eval(ien_r, ist_tmp);
            end
          end
          PORT_TMK: tmask_nxt = wd;
          PORT_ACK: begin
            ist_tmp = ist_r & ~wd;
            ist_nxt = ist_tmp;
            irq_nxt = irq_eval(ien_r, ist_tmp);
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        if (cmd_r[4]) begin
          rtc_nxt   = '0;
          ts_nxt    = 3'b000;
          tmask_nxt = TMASK_RESET;
        end else begin
          rtc_nxt = rtc_tick;
          if (ien_r[0]) begin
            if (ist_r[7]) begin
              ist_tmp = ist_r & STA_TIME_CLR;
              ist_nxt = ist_tmp;
              irq_nxt = irq_eval(ien_r, ist_tmp);
              wake    = mod3_zero(rtc_tick[0]);
            end else if (!ien_r[1] || (tmask_r == 8'h00)) begin
              ist_tmp = ist_r & STA_TIME_CLR;
              ist_nxt = ist_tmp;
              irq_nxt = irq_eval(ien_r, ist_tmp);
            end else if (tev != TEV_NONE) begin
              ts_nxt = tev;
              if (|(tmask_r[2:0] & tev)) begin
                ist_tmp = ist_r | STA_TIME_BIT;
                ist_nxt = ist_tmp;
                irq_nxt = irq_eval(ien_r, ist_tmp);
                wake    = 1'b1;
              end
            end
          end
        end
      end
      OP_FLAP_OPEN: begin
        if (ien_r[5] && ien_r[0]) begin
          ist_tmp = ist_r | STA_FLAP_BITS;
          ist_nxt = ist_tmp;
          irq_nxt = irq_eval(ien_r, ist_tmp);
          wake    = 1'b1;
        end
      end
      OP_FLAP_CLOSE: begin
        ist_tmp = ist_r & STA_FLAP_CLR;
        ist_nxt = ist_tmp;
        irq_nxt = irq_eval(ien_r, ist_tmp);
        wake    = 1'b1;
      end
      OP_BATT_LOW: begin
        ist_tmp = ist_r | STA_BATT_BIT;
        ist_nxt = ist_tmp;
        irq_nxt = irq_eval(ien_r, ist_tmp);
      end
      OP_SOFT_RESET: begin
        // Segment zero is repaged with the old command register, and the line is
        // evaluated with the old status before the status is cleared.
        seg_nxt   = '0;
        lower_nxt = cmd_r[2];
        rtc_nxt   = '0;
        ts_nxt    = 3'b000;
        tmask_nxt = TMASK_RESET;
        cmd_nxt   = 8'h00;
        ien_nxt   = IEN_RESET;
        irq_nxt   = irq_eval(IEN_RESET, ist_r);
        ist_nxt   = 8'h00;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= '0;
      rtc_r   <= '0;
      ts_r    <= 3'b000;
      tmask_r <= TMASK_RESET;
      ien_r   <= IEN_RESET;
      ist_r   <= 8'h00;
      cmd_r   <= 8'h00;
      irq_r   <= 1'b0;
      lcd_r   <= '0;
      scr_r   <= 16'h0000;
      spk_r   <= 1'b0;
      lower_r <= 1'b0;
    end else if (en) begin
      seg_r   <= seg_nxt;
      rtc_r   <= rtc_nxt;
      ts_r    <= ts_nxt;
      tmask_r <= tmask_nxt;
      ien_r   <= ien_nxt;
      ist_r   <= ist_nxt;
      cmd_r   <= cmd_nxt;
      irq_r   <= irq_nxt;
      lcd_r   <= lcd_nxt;
      scr_r   <= scr_nxt;
      spk_r   <= spk_nxt;
      lower_r <= lower_nxt;
    end
  end

  always_comb begin
    res_nxt.read_data        = rd;
    res_nxt.irq_out          = irq_nxt;
    res_nxt.wake_cpu         = wake;
    res_nxt.snooze_cpu       = snooze;
    res_nxt.speaker_out      = spk_nxt;
    res_nxt.segment_banks    = seg_nxt;
    res_nxt.seg0_lower_bank  = lower_nxt ? 8'd32 : 8'd0;
    res_nxt.lcd_bases        = lcd_nxt;
    res_nxt.screen_base_word = scr_nxt;
  end

endmodule

`default_nettype wire

@@ src/gate_array_rtc_interrupt_ports_unit.sv @@
// Top level of the gate array register block: input stage, result register, config.
//
// Each input item is one port read, port write, 5 ms clock tick, flap open or
// close, battery-low event or soft reset; each item yields exactly one result
// item on the out_ channel, in order. Both channels use valid/ready.
// An accepted item is held in an input register until it can advance; the
// register update and the result are formed from it by single-level logic and
// the result is captured in the output register. One item per cycle is
// sustained while the receiver keeps out_ready high: the input register frees
// as soon as its item moves into the output register, which happens whenever
// the output register is empty or being taken.
// When the receiver stalls, the output register holds its item, the input
// register fills, and in_ready drops until out_ready returns.
// cfg_we writes the screen width (index 0) or height (index 1) code, read back
// through the LCD ports 0x70 and 0x71; write only while the block is idle.
// A synchronous reset (rst_n low) empties both stages and returns the core and
// config registers to their reset values; the item and result data are not reset.
`timescale 1ns / 1ps
`default_nettype none

module gate_array_rtc_interrupt_ports_unit
  import garip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [15:0] in_port_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_key_pressed,
  input  wire logic [63:0] in_key_matrix,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data,
  output logic             out_irq_out,
  output logic             out_wake_cpu,
  output logic             out_snooze_cpu,
  output logic             out_speaker_out,
  output logic [31:0]      out_segment_banks,
  output logic [7:0]       out_seg0_lower_bank,
  output logic [63:0]      out_lcd_bases,
  output logic [15:0]      out_screen_base_word,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic    s1_v_r, s1_v_nxt;
  item_t   s1_item_r;
  logic    out_v_r, out_v_nxt;
  result_t out_res_r;
  result_t res_nxt;
  logic    s1_adv;
  logic    in_acc;
  logic [7:0] width_r;
  logic [7:0] height_r;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign s1_v_nxt  = in_acc || (s1_v_r && !s1_adv);
  assign out_v_nxt = s1_adv || (out_v_r && !out_ready);

  garip_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (s1_adv),
    .item        (s1_item_r),
    .width_code  (width_r),
    .height_code (height_r),
    .res_nxt     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      width_r  <= 8'h00;
      height_r <= 8'h00;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_wdata;
          CFG_HEIGHT: height_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.operation    <= in_operation;
      s1_item_r.port_address <= in_port_address;
      s1_item_r.write_data   <= in_write_data;
      s1_item_r.key_pressed  <= in_key_pressed;
      s1_item_r.key_matrix   <= in_key_matrix;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid            = out_v_r;
  assign out_read_data        = out_res_r.read_data;
  assign out_irq_out          = out_res_r.irq_out;
  assign out_wake_cpu         = out_res_r.wake_cpu;
  assign out_snooze_cpu       = out_res_r.snooze_cpu;
  assign out_speaker_out      = out_res_r.speaker_out;
  assign out_segment_banks    = out_res_r.segment_banks;
  assign out_seg0_lower_bank  = out_res_r.seg0_lower_bank;
  assign out_lcd_bases        = out_res_r.lcd_bases;
  assign out_screen_base_word = out_res_r.screen_base_word;

`ifndef ASSERT_OFF
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid)
    else $error("item left the input stage but no result became valid");

  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !s1_v_r) |=> !out_valid)
    else $error("result reappeared with no item in the input stage");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_v_r))
    else $error("input stalled while a stage was free");

  a_snooze_reads_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_snooze_cpu) |-> (out_read_data == IDLE_READ_VAL && !out_wake_cpu))
    else $error("snooze result carries read data or a wake pulse");
`endif

endmodule

`default_nettype wire

@@ tb/gate_array_rtc_interrupt_ports_unit_tb.sv @@
// Self-checking testbench for the gate array register and clock block.
`timescale 1ns / 1ps

module gate_array_rtc_interrupt_ports_unit_tb;
  import garip_pkg::*;

  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam int         LIMIT      = 200000;
  localparam int         STALL_AT   = 60;
  localparam int         STALL_LEN  = 80;
  localparam int         TICK_RUN   = 140;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = 3'd0;
  logic [15:0] in_port_address = 16'h0000;
  logic [7:0]  in_write_data = 8'h00;
  logic        in_key_pressed = 1'b0;
  logic [63:0] in_key_matrix = 64'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_irq_out;
  logic        out_wake_cpu;
  logic        out_snooze_cpu;
  logic        out_speaker_out;
  logic [31:0] out_segment_banks;
  logic [7:0]  out_seg0_lower_bank;
  logic [63:0] out_lcd_bases;
  logic [15:0] out_screen_base_word;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;

  gate_array_rtc_interrupt_ports_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_port_address(in_port_address),
    .in_write_data(in_write_data), .in_key_pressed(in_key_pressed),
    .in_key_matrix(in_key_matrix),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data), .out_irq_out(out_irq_out),
    .out_wake_cpu(out_wake_cpu), .out_snooze_cpu(out_snooze_cpu),
    .out_speaker_out(out_speaker_out), .out_segment_banks(out_segment_banks),
    .out_seg0_lower_bank(out_seg0_lower_bank), .out_lcd_bases(out_lcd_bases),
    .out_screen_base_word(out_screen_base_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predicted register state of the gate array.
  logic [7:0]  seg_bank [4];
  logic [7:0]  rtc_cnt [5];
  logic [2:0]  tmr_stat;
  logic [7:0]  tmr_mask, ien, ist, cmd, low_bank, width_code, height_code;
  logic        irq_lvl, spk, wake_p, snooze_p;
  logic [15:0] lcd_base [4];
  logic [15:0] scr_base;

  item_t       pend_q [$];
  result_t     expect_q [$];
  logic [7:0]  port_tab [20];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          accepted_cnt = 0;
  int          stall_left = 0;
  bit          stall_done = 1'b0;
  int          cycle_cnt = 0;
  int          err_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void status_put(input logic [7:0] v);
    ist = v;
    // Enable and status bits are paired by position, whatever their sources.
    irq_lvl = ien[0] && ((ien & ist) != 8'h00);
  endfunction

  function automatic void segment_put(input logic [1:0] idx, input logic [7:0] bank);
    seg_bank[idx] = bank;
    if (idx == 2'd0)
      low_bank = cmd[2] ? 8'd32 : 8'd0;
  endfunction

  function automatic void rtc_clear();
    rtc_cnt = '{default: 8'h00};
    tmr_stat = TEV_NONE;
    tmr_mask = TMASK_RESET;
  endfunction

  function automatic void gate_step(input item_t it, output result_t r);
    logic [7:0] p;
    logic [7:0] acc;
    logic [2:0] ev;
    p = it.port_address[7:0];
    r.read_data = IDLE_READ_VAL;
    wake_p = 1'b0;
    snooze_p = 1'b0;
    case (it.operation)
      OP_READ: begin
        case (p)
          PORT_COM: r.read_data = STA_READ_VAL;
          PORT_INT: r.read_data = ist;
          PORT_KBD: begin
            if (ien[7] && !it.key_pressed) begin
              snooze_p = 1'b1;
            end else begin
              acc = 8'h00;
              // A row takes part when its bit of the high address byte is low.
              for (int i = 0; i < KEY_ROWS; i++)
                if (!it.port_address[8 + i])
                  acc |= it.key_matrix[8 * i +: 8];
              r.read_data = ~acc;
            end
          end
          PORT_TMK: r.read_data = {5'b00000, tmr_stat};
          PORT_SEG0, PORT_SEG1, PORT_SEG2, PORT_SEG3, PORT_RTC4:
            r.read_data = rtc_cnt[p[2:0]];
          PORT_LCD0: r.read_data = width_code;
          PORT_LCD1: r.read_data = height_code;
          PORT_UDAT0, PORT_UDAT1: r.read_data = 8'h00;
          PORT_USTA: r.read_data = USTA_READ_VAL;
          default: r.read_data = IDLE_READ_VAL;
        endcase
      end
      OP_WRITE: begin
        if (p >= PORT_LCD0 && p <= PORT_SCR) begin
          if (p == PORT_SCR)
            scr_base = {it.port_address[15:8], it.write_data};
          else
            lcd_base[p[1:0]] = {it.port_address[15:8], it.write_data};
        end else begin
          case (p)
            PORT_SEG0, PORT_SEG1, PORT_SEG2, PORT_SEG3: segment_put(p[1:0], it.write_data);
            PORT_COM: begin
              cmd = it.write_data;
              if (cmd[4])
                rtc_clear();
              if (!cmd[7])
                spk = cmd[6];
              segment_put(2'd0, seg_bank[0]);
            end
            PORT_INT: begin
              ien = it.write_data;
              status_put(ist);
            end
            PORT_TACK: begin
              tmr_stat &= ~it.write_data[2:0];
              if (tmr_stat == TEV_NONE)
                status_put(ist & STA_TIME_CLR);
            end
            PORT_TMK: tmr_mask = it.write_data;
            PORT_ACK: status_put(ist & ~it.write_data);
            // The EPROM register has no visible output.
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        ev = TEV_NONE;
        if (cmd[4]) begin
          rtc_clear();
        end else begin
          rtc_cnt[0] = rtc_cnt[0] + 8'd1;
          if (rtc_cnt[0] > RTC_TICK_MAX) begin
            rtc_cnt[0] = 8'd0;
          end else begin
            if (rtc_cnt[0][0])
              ev = TEV_TICK;
            if (rtc_cnt[0] == RTC_SEC_AT) begin
              rtc_cnt[1] = rtc_cnt[1] + 8'd1;
              ev = TEV_SEC;
              if (rtc_cnt[1] > RTC_MIN_MAX) begin
                rtc_cnt[1] = 8'd0;
                rtc_cnt[2] = rtc_cnt[2] + 8'd1;
                if (rtc_cnt[2] == 8'd0) begin
                  rtc_cnt[3] = rtc_cnt[3] + 8'd1;
                  if (rtc_cnt[3] == 8'd0) begin
                    rtc_cnt[4] = rtc_cnt[4] + 8'd1;
                    if (rtc_cnt[4] > RTC_DAY_MAX)
                      rtc_cnt[4] = 8'd0;
                  end
                end
              end
              if (rtc_cnt[1] == RTC_HALF_MIN)
                ev = TEV_MIN;
            end
          end
          if (ien[0]) begin
            if (ist[7]) begin
              // Flap open: time interrupts are dropped, the processor is woken
              // every third tick count instead.
              status_put(ist & STA_TIME_CLR);
              if (rtc_cnt[0] % 3 == 0)
                wake_p = 1'b1;
            end else if (!ien[1] || tmr_mask == 8'h00) begin
              status_put(ist & STA_TIME_CLR);
            end else if (ev != TEV_NONE) begin
              tmr_stat = ev;
              if ((tmr_mask[2:0] & ev) != 3'b000) begin
                status_put(ist | STA_TIME_BIT);
                wake_p = 1'b1;
              end
            end
          end
        end
      end
      OP_FLAP_OPEN: begin
        if (ien[5] && ien[0]) begin
          status_put(ist | STA_FLAP_BITS);
          wake_p = 1'b1;
        end
      end
      OP_FLAP_CLOSE: begin
        status_put(ist & STA_FLAP_CLR);
        wake_p = 1'b1;
      end
      OP_BATT_LOW: status_put(ist | STA_BATT_BIT);
      OP_SOFT_RESET: begin
        // Segments are repaged under the old command, and the line is
        // evaluated with the old status before the status is cleared.
        for (int i = 0; i < 4; i++)
          segment_put(i[1:0], 8'h00);
        rtc_clear();
        cmd = 8'h00;
        ien = IEN_RESET;
        status_put(ist);
        ist = 8'h00;
        tmr_stat = TEV_NONE;
      end
      default: ;
    endcase
    r.irq_out = irq_lvl;
    r.wake_cpu = wake_p;
    r.snooze_cpu = snooze_p;
    r.speaker_out = spk;
    r.segment_banks = {seg_bank[3], seg_bank[2], seg_bank[1], seg_bank[0]};
    r.seg0_lower_bank = low_bank;
    r.lcd_bases = {lcd_base[3], lcd_base[2], lcd_base[1], lcd_base[0]};
    r.screen_base_word = scr_base;
  endfunction

  function automatic void queue_item(input logic [2:0] op, input logic [15:0] addr,
                                     input logic [7:0] data, input logic key,
                                     input logic [63:0] km);
    item_t it;
    it.operation = op;
    it.port_address = addr;
    it.write_data = data;
    it.key_pressed = key;
    it.key_matrix = km;
    pend_q.push_back(it);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    sel;
    sel = $urandom_range(0, 99);
    if (sel < 30)      it.operation = OP_READ;
    else if (sel < 65) it.operation = OP_WRITE;
    else if (sel < 85) it.operation = OP_TICK;
    else if (sel < 89) it.operation = OP_FLAP_OPEN;
    else if (sel < 93) it.operation = OP_FLAP_CLOSE;
    else if (sel < 96) it.operation = OP_BATT_LOW;
    else if (sel < 98) it.operation = OP_SOFT_RESET;
    else               it.operation = OP_UNUSED;
    it.port_address = 16'($urandom);
    if ($urandom_range(0, 99) < 85)
      it.port_address[7:0] = port_tab[$urandom_range(0, 19)];
    it.write_data = 8'($urandom);
    // Keep the clock running most of the time a command is written.
    if (it.port_address[7:0] == PORT_COM && $urandom_range(0, 3) != 0)
      it.write_data[4] = 1'b0;
    it.key_pressed = 1'($urandom);
    it.key_matrix = {$urandom, $urandom};
    return it;
  endfunction

  function automatic void field_check(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= 50)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pend_q.size() != 0 || expect_q.size() != 0 || in_valid);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH)
      width_code = val;
    else
      height_code = val;
  endtask

  // Input side: offers queued items and predicts each accepted one.
  always @(posedge clk) begin : drive_proc
    item_t   nxt;
    item_t   took;
    result_t pred;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        took.operation = in_operation;
        took.port_address = in_port_address;
        took.write_data = in_write_data;
        took.key_pressed = in_key_pressed;
        took.key_matrix = in_key_matrix;
        gate_step(took, pred);
        expect_q.push_back(pred);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pend_q.pop_front();
          in_valid <= 1'b1;
          in_operation <= nxt.operation;
          in_port_address <= nxt.port_address;
          in_write_data <= nxt.write_data;
          in_key_pressed <= nxt.key_pressed;
          in_key_matrix <= nxt.key_matrix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!stall_done && accepted_cnt >= STALL_AT) begin
      stall_done <= 1'b1;
      stall_left <= STALL_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_proc
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expect_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual read_data 0x%0h",
                 $time, out_read_data);
      end else begin
        want = expect_q.pop_front();
        field_check("read_data", want.read_data, out_read_data);
        field_check("irq_out", want.irq_out, out_irq_out);
        field_check("wake_cpu", want.wake_cpu, out_wake_cpu);
        field_check("snooze_cpu", want.snooze_cpu, out_snooze_cpu);
        field_check("speaker_out", want.speaker_out, out_speaker_out);
        field_check("segment_banks", want.segment_banks, out_segment_banks);
        field_check("seg0_lower_bank", want.seg0_lower_bank, out_seg0_lower_bank);
        field_check("lcd_bases", want.lcd_bases, out_lcd_bases);
        field_check("screen_base_word", want.screen_base_word, out_screen_base_word);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [7:0] pick;
    port_tab = '{PORT_LCD0, PORT_LCD1, PORT_LCD2, PORT_LCD3, PORT_SCR,
                 PORT_COM, PORT_INT, PORT_KBD, PORT_EPR, PORT_TACK, PORT_TMK, PORT_ACK,
                 PORT_SEG0, PORT_SEG1, PORT_SEG2, PORT_SEG3, PORT_RTC4,
                 PORT_UDAT0, PORT_UDAT1, PORT_USTA};
    seg_bank = '{default: 8'h00};
    lcd_base = '{default: 16'h0000};
    rtc_clear();
    ien = IEN_RESET;
    ist = 8'h00;
    cmd = 8'h00;
    irq_lvl = 1'b0;
    spk = 1'b0;
    low_bank = 8'h00;
    scr_base = 16'h0000;
    width_code = 8'h00;
    height_code = 8'h00;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(CFG_WIDTH, 8'hFF);
    cfg_write(CFG_HEIGHT, 8'h00);
    send_idle_pct = 18;
    recv_idle_pct = 67;

    queue_item(OP_READ, {8'h00, PORT_LCD0}, 8'h00, 1'b0, 64'h0);
    queue_item(OP_READ, {8'hFF, PORT_LCD1}, 8'h00, 1'b0, 64'h0);
    queue_item(OP_READ, {8'h00, PORT_COM}, 8'h00, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'hFF, PORT_SEG0}, 8'hFF, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'h00, PORT_COM}, 8'h44, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'h00, PORT_COM}, 8'hC0, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'hFF, PORT_LCD3}, 8'hFF, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'hFF, PORT_SCR}, 8'hFF, 1'b0, 64'h0);
    queue_item(OP_WRITE, 16'h0000, 8'hFF, 1'b0, 64'h0);
    queue_item(OP_READ, 16'hFFFF, 8'h00, 1'b0, 64'h0);
    queue_item(OP_READ, {8'h00, PORT_USTA}, 8'h00, 1'b0, 64'h0);
    queue_item(OP_TICK, 16'h0000, 8'h00, 1'b0, 64'h0);
    queue_item(OP_READ, {8'h00, PORT_SEG0}, 8'h00, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'h00, PORT_TACK}, 8'h07, 1'b0, 64'h0);
    // Soft reset with the flap bit pending leaves the line high.
    queue_item(OP_FLAP_OPEN, 16'h0000, 8'h00, 1'b0, 64'h0);
    queue_item(OP_BATT_LOW, 16'h0000, 8'h00, 1'b0, 64'h0);
    queue_item(OP_SOFT_RESET, 16'h0000, 8'h00, 1'b0, 64'h0);
    queue_item(OP_FLAP_CLOSE, 16'h0000, 8'h00, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'h00, PORT_INT}, 8'hA3, 1'b0, 64'h0);
    queue_item(OP_READ, {8'h00, PORT_KBD}, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(OP_READ, {8'h00, PORT_KBD}, 8'h00, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(OP_READ, {8'hFE, PORT_KBD}, 8'h00, 1'b1, {$urandom, $urandom});
    queue_item(OP_WRITE, {8'h00, PORT_COM}, 8'h10, 1'b0, 64'h0);
    queue_item(OP_TICK, 16'h0000, 8'h00, 1'b0, 64'h0);
    queue_item(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(OP_WRITE, {8'h00, PORT_TMK}, 8'h00, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'h00, PORT_COM}, 8'h00, 1'b0, 64'h0);
    queue_item(OP_TICK, 16'h0000, 8'h00, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'h00, PORT_ACK}, 8'hFF, 1'b0, 64'h0);
    repeat (150) pend_q.push_back(random_item());
    wait_idle();

    cfg_write(CFG_WIDTH, 8'h00);
    cfg_write(CFG_HEIGHT, 8'hFF);
    send_idle_pct = 67;
    recv_idle_pct = 18;
    repeat (150) pend_q.push_back(random_item());
    wait_idle();

    cfg_write(CFG_WIDTH, 8'($urandom));
    cfg_write(CFG_HEIGHT, 8'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (30) pend_q.push_back(random_item());
    // A clock run from a clean state with all timer events enabled reaches
    // the first seconds event.
    queue_item(OP_SOFT_RESET, 16'h0000, 8'h00, 1'b0, 64'h0);
    queue_item(OP_WRITE, {8'h00, PORT_TMK}, 8'h07, 1'b0, 64'h0);
    for (int n = 0; n < TICK_RUN; n++) begin
      if ($urandom_range(0, 49) != 0) begin
        queue_item(OP_TICK, 16'($urandom), 8'($urandom), 1'($urandom), 64'h0);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            pick = ($urandom_range(0, 1) != 0) ? PORT_TMK : (PORT_SEG0 | 8'($urandom_range(0, 4)));
            queue_item(OP_READ, {8'h00, pick}, 8'h00, 1'b0, 64'h0);
          end
          1: queue_item(OP_WRITE, {8'h00, PORT_TACK}, 8'($urandom), 1'b0, 64'h0);
          2: queue_item(OP_WRITE, {8'h00, PORT_ACK}, 8'($urandom), 1'b0, 64'h0);
          default: queue_item(($urandom_range(0, 1) != 0) ? OP_FLAP_OPEN : OP_FLAP_CLOSE,
                              16'h0000, 8'h00, 1'b0, 64'h0);
        endcase
      end
    end
    wait_idle();
    repeat (8) @(posedge clk);

    if (err_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/garip_pkg.sv
src/garip_kbd.sv
src/garip_rtc.sv
src/garip_core.sv
src/gate_array_rtc_interrupt_ports_unit.sv
tb/gate_array_rtc_interrupt_ports_unit_tb.sv
